@@ rtl/adam_pkg.sv @@
// ----------------------------------------------------------------------------
// adam_pkg
// Shared types and constants of the fixed-point Adam update block.
// ----------------------------------------------------------------------------
package adam_pkg;

  localparam int IdxW    = 10;
  localparam int ValW    = 32;
  localparam int DecW    = 16;
  localparam int PowW    = 17;
  localparam int M1W     = 32;
  localparam int M2W     = 48;
  localparam int EpsW    = 32;
  localparam int HatW    = 48;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 2;

  localparam int unsigned DefElements = 1024;

  localparam logic [DecW-1:0] LrReset  = 16'd66;
  localparam logic [DecW-1:0] B1Reset  = 16'd58982;
  localparam logic [DecW-1:0] B2Reset  = 16'd65470;
  localparam logic [EpsW-1:0] EpsReset = 32'd43;
  localparam logic [PowW-1:0] One      = 17'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLr  = 2'd0,
    CfgB1  = 2'd1,
    CfgB2  = 2'd2,
    CfgEps = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [IdxW-1:0]        elem_index;
    logic signed [ValW-1:0] param_value;
    logic signed [ValW-1:0] grad_value;
    logic                   starts_step;
  } adam_in_t;

  typedef struct packed {
    logic [IdxW-1:0]        elem_index_out;
    logic signed [ValW-1:0] param_updated;
  } adam_out_t;

endpackage

@@ rtl/adam_optimizer_update.sv @@
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Fixed-point Adam update of one parameter element per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one element per
// item: index, Q16.16 value, Q16.16 gradient and a flag that opens a new
// optimizer step. Output channel (out_valid_o / out_stall_i / out_data_o)
// returns one item per input item, in order: the index and the new value.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i);
// the user must write it only while the block is idle; it is not enforced.
// Throughput: one item per cycle unless the output stalls or the clear sweep
// runs. The moment store is a RAM with one read and one write port; an entry
// is read from stage a and written back from stage b; back-to-back items on
// the same entry are forwarded. The three 48-stage dividers and the 32-stage
// square root make up most of the pipeline.
// Reset: the moment store is cleared by a sweep over all ELEMENTS entries,
// one entry a cycle; in_stall_o stays high until it is done.
// A stalled output holds its item; the pipeline keeps moving while its last
// stage is empty and freezes as a whole once it is not.
// ----------------------------------------------------------------------------
module adam_optimizer_update #(
  parameter int unsigned ELEMENTS = adam_pkg::DefElements
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  adam_pkg::adam_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output adam_pkg::adam_out_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [adam_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [adam_pkg::CfgW-1:0]    cfg_wdata_i
);
  import adam_pkg::*;

  localparam int          SlotW      = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int          RecipShift = 20;
  localparam int unsigned Recip      = (32'd1 << RecipShift) / ELEMENTS;
  localparam logic [31:0] ElemsW     = 32'(ELEMENTS);
  localparam logic [31:0] RecipW     = 32'(Recip);
  localparam int          MemW       = M1W + M2W;
  localparam int          DenW       = HatW + 1;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] p;
    logic            neg;
    logic [M2W-1:0]  m2;
    logic [PowW-1:0] c2;
  } d1_pay_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] p;
    logic            neg;
    logic [HatW-1:0] m1hat;
  } d2_pay_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] p;
    logic            neg;
  } d3_pay_t;

  // ---------------- configuration ----------------
  logic [DecW-1:0] lr_q, b1_q, b2_q;
  logic [EpsW-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LrReset;
      b1_q  <= B1Reset;
      b2_q  <= B2Reset;
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgLr:   lr_q  <= cfg_wdata_i[DecW-1:0];
        CfgB1:   b1_q  <= cfg_wdata_i[DecW-1:0];
        CfgB2:   b2_q  <= cfg_wdata_i[DecW-1:0];
        CfgEps:  eps_q <= cfg_wdata_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic f_valid;
  logic out_valid_q;
  logic en;
  logic accept;
  logic out_ld;
  logic clr_busy_q;
  logic [SlotW-1:0] clr_addr_q;

  assign en         = !(out_valid_q && out_stall_i && f_valid);
  assign in_stall_o = clr_busy_q || !en;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_ld     = !out_valid_q || !out_stall_i;

  // clear sweep of the moment store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == SlotW'(ELEMENTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------- decay powers, advanced on a new step ----------------
  logic [PowW-1:0] b1p_q, b2p_q;
  logic [32:0]     b1p_prod, b2p_prod;
  logic [PowW-1:0] b1p_new, b2p_new;
  logic [PowW-1:0] c1_new, c2_new;

  assign b1p_prod = 33'(b1p_q) * 33'(b1_q);
  assign b2p_prod = 33'(b2p_q) * 33'(b2_q);
  assign b1p_new  = in_data_i.starts_step ? PowW'((b1p_prod + 33'd32768) >> 16) : b1p_q;
  assign b2p_new  = in_data_i.starts_step ? PowW'((b2p_prod + 33'd32768) >> 16) : b2p_q;
  // no correction yet counts as one
  assign c1_new   = (b1p_new == One) ? One : PowW'(One - b1p_new);
  assign c2_new   = (b2p_new == One) ? One : PowW'(One - b2p_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1p_q <= One;
      b2p_q <= One;
    end else if (accept) begin
      b1p_q <= b1p_new;
      b2p_q <= b2p_new;
    end
  end

  // ---------------- stage a: accepted item ----------------
  logic        [ValW-1:0] gmag_in;
  logic        [31:0]     qprod_in;
  logic                   a_valid_q;
  logic        [IdxW-1:0] a_idx_q, a_qest_q;
  logic signed [ValW-1:0] a_p_q, a_g_q;
  logic        [63:0]     a_sq_q;
  logic        [PowW-1:0] a_c1_q, a_c2_q;

  assign gmag_in  = in_data_i.grad_value[ValW-1] ? ValW'(-in_data_i.grad_value)
                                                 : ValW'(in_data_i.grad_value);
  assign qprod_in = 32'(in_data_i.elem_index) * RecipW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_idx_q  <= in_data_i.elem_index;
      a_qest_q <= IdxW'(qprod_in >> RecipShift);
      a_p_q    <= in_data_i.param_value;
      a_g_q    <= in_data_i.grad_value;
      a_sq_q   <= 64'(gmag_in) * 64'(gmag_in);
      a_c1_q   <= c1_new;
      a_c2_q   <= c2_new;
    end
  end

  // slot = index modulo ELEMENTS: reciprocal estimate, then one correction
  logic [31:0]      a_rem, a_rem_fix;
  logic [SlotW-1:0] a_slot;
  logic [M2W-1:0]   a_g2;

  assign a_rem     = 32'(a_idx_q) - 32'(a_qest_q) * ElemsW;
  assign a_rem_fix = (a_rem >= ElemsW) ? (a_rem - ElemsW) : a_rem;
  assign a_slot    = a_rem_fix[SlotW-1:0];
  assign a_g2      = M2W'((a_sq_q + 64'd32768) >> 16);

  // ---------------- moment store ----------------
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [MemW-1:0]   ram_wdata;
  logic [MemW-1:0]   ram_rdata;
  logic              b_valid_q;
  logic [SlotW-1:0]  b_slot_q;
  logic signed [M1W-1:0] m1_new;
  logic        [M2W-1:0] m2_new;

  assign ram_we    = clr_busy_q || (b_valid_q && en);
  assign ram_waddr = clr_busy_q ? clr_addr_q : b_slot_q;
  assign ram_wdata = clr_busy_q ? '0 : {m2_new, m1_new};

  adam_ram #(
    .Width (MemW),
    .Depth (ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (en),
    .raddr_i (a_slot),
    .rdata_o (ram_rdata)
  );

  // ---------------- stage b: read-modify-write ----------------
  logic                   fwd_hit;
  logic        [IdxW-1:0] b_idx_q;
  logic signed [ValW-1:0] b_p_q, b_g_q;
  logic        [M2W-1:0]  b_g2_q;
  logic        [PowW-1:0] b_c1_q, b_c2_q;
  logic                   b_fwd_q;
  logic signed [M1W-1:0]  b_fm1_q;
  logic        [M2W-1:0]  b_fm2_q;

  // the entry being written this edge is the one read this edge
  assign fwd_hit = b_valid_q && (b_slot_q == a_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_slot_q <= a_slot;
      b_idx_q  <= a_idx_q;
      b_p_q    <= a_p_q;
      b_g_q    <= a_g_q;
      b_g2_q   <= a_g2;
      b_c1_q   <= a_c1_q;
      b_c2_q   <= a_c2_q;
      b_fwd_q  <= fwd_hit;
      b_fm1_q  <= m1_new;
      b_fm2_q  <= m2_new;
    end
  end

  logic signed [M1W-1:0] m1_old;
  logic        [M2W-1:0] m2_old;
  logic        [PowW-1:0] om_b1, om_b2;
  logic signed [50:0]    m1_pa, m1_pb, m1_sum;
  logic        [50:0]    m1_mag;
  logic        [50:0]    m1_rnd;
  logic        [M1W-1:0] m1_rl;
  logic        [64:0]    m2_sum;

  assign m1_old = b_fwd_q ? b_fm1_q : $signed(ram_rdata[M1W-1:0]);
  assign m2_old = b_fwd_q ? b_fm2_q : ram_rdata[MemW-1:M1W];
  assign om_b1  = PowW'(One - PowW'(b1_q));
  assign om_b2  = PowW'(One - PowW'(b2_q));

  assign m1_pa  = 51'($signed({1'b0, b1_q})) * 51'(m1_old);
  assign m1_pb  = 51'($signed({1'b0, om_b1})) * 51'(b_g_q);
  assign m1_sum = m1_pa + m1_pb;
  // round half away from zero
  assign m1_mag = m1_sum[50] ? 51'(-m1_sum) : 51'(m1_sum);
  assign m1_rnd = (m1_mag + 51'd32768) >> 16;
  assign m1_rl  = m1_rnd[M1W-1:0];
  assign m1_new = m1_sum[50] ? $signed(~m1_rl + 1'b1) : $signed(m1_rl);

  assign m2_sum = 65'(b2_q) * 65'(m2_old) + 65'(om_b2) * 65'(b_g2_q) + 65'd32768;
  assign m2_new = m2_sum[63:16];

  // ---------------- stage c ----------------
  logic                  c_valid_q;
  logic [IdxW-1:0]       c_idx_q;
  logic [ValW-1:0]       c_p_q;
  logic                  c_neg_q;
  logic [M1W-1:0]        c_m1mag_q;
  logic [M2W-1:0]        c_m2_q;
  logic [PowW-1:0]       c_c1_q, c_c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_idx_q   <= b_idx_q;
      c_p_q     <= b_p_q;
      c_neg_q   <= m1_new[M1W-1];
      c_m1mag_q <= m1_rl;
      c_m2_q    <= m2_new;
      c_c1_q    <= b_c1_q;
      c_c2_q    <= b_c2_q;
    end
  end

  // ---------------- bias correction of the first moment ----------------
  d1_pay_t         d1_in, d1_out;
  logic            d1_valid;
  logic [HatW-1:0] d1_quo;
  logic            d1_ovf;

  assign d1_in = '{idx: c_idx_q, p: c_p_q, neg: c_neg_q, m2: c_m2_q, c2: c_c2_q};

  adam_div #(
    .DenW (PowW),
    .QuoW (HatW),
    .PayW ($bits(d1_pay_t))
  ) u_div_m1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .num_i   ({(HatW+PowW-M1W-16)'(0), c_m1mag_q, 16'd0}),
    .den_i   (c_c1_q),
    .pay_i   (d1_in),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .ovf_o   (d1_ovf),
    .pay_o   (d1_out)
  );

  // ---------------- bias correction of the second moment ----------------
  d2_pay_t         d2_in, d2_out;
  logic            d2_valid;
  logic [HatW-1:0] d2_quo;
  logic            d2_ovf;
  logic [HatW-1:0] m1hat;
  logic [HatW-1:0] m2hat;

  assign m1hat = d1_ovf ? '1 : d1_quo;
  assign d2_in = '{idx: d1_out.idx, p: d1_out.p, neg: d1_out.neg, m1hat: m1hat};

  adam_div #(
    .DenW (PowW),
    .QuoW (HatW),
    .PayW ($bits(d2_pay_t))
  ) u_div_m2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_valid),
    .num_i   ({(HatW+PowW-M2W-16)'(0), d1_out.m2, 16'd0}),
    .den_i   (d1_out.c2),
    .pay_i   (d2_in),
    .valid_o (d2_valid),
    .quo_o   (d2_quo),
    .ovf_o   (d2_ovf),
    .pay_o   (d2_out)
  );

  // saturate to 48 bits
  assign m2hat = d2_ovf ? '1 : d2_quo;

  // ---------------- square root ----------------
  d2_pay_t         s_out;
  logic            s_valid;
  logic [31:0]     s_root;

  adam_sqrt #(
    .RootW (32),
    .PayW  ($bits(d2_pay_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d2_valid),
    .x_i     ({m2hat, 16'd0}),
    .pay_i   (d2_out),
    .valid_o (s_valid),
    .root_o  (s_root),
    .pay_o   (s_out)
  );

  // ---------------- stage e: denominator and numerator ----------------
  logic [DenW-1:0] den_raw;
  logic            e_valid_q;
  logic [IdxW-1:0] e_idx_q;
  logic [ValW-1:0] e_p_q;
  logic            e_neg_q;
  logic [DenW-1:0] e_den_q;
  logic [63:0]     e_num_q;

  assign den_raw = DenW'({s_root, 16'd0}) + DenW'(eps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_idx_q <= s_out.idx;
      e_p_q   <= s_out.p;
      e_neg_q <= s_out.neg;
      // a zero denominator counts as one LSB
      e_den_q <= (den_raw == '0) ? DenW'(1) : den_raw;
      e_num_q <= 64'(lr_q) * 64'(s_out.m1hat);
    end
  end

  // ---------------- step size ----------------
  d3_pay_t         d3_in, d3_out;
  logic [HatW-1:0] d3_quo;
  logic            d3_ovf;

  assign d3_in = '{idx: e_idx_q, p: e_p_q, neg: e_neg_q};

  adam_div #(
    .DenW (DenW),
    .QuoW (HatW),
    .PayW ($bits(d3_pay_t))
  ) u_div_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .num_i   ({(HatW+DenW-64-16)'(0), e_num_q, 16'd0}),
    .den_i   (e_den_q),
    .pay_i   (d3_in),
    .valid_o (f_valid),
    .quo_o   (d3_quo),
    .ovf_o   (d3_ovf),
    .pay_o   (d3_out)
  );

  // ---------------- apply step, saturate, output register ----------------
  logic        [DenW-1:0] step;
  logic signed [50:0]     p_ext, step_ext, res;
  logic signed [ValW-1:0] res_sat;
  adam_out_t              out_data_q;

  assign step     = d3_ovf ? (DenW'(1) << HatW) : {1'b0, d3_quo};
  assign p_ext    = 51'($signed(d3_out.p));
  assign step_ext = $signed({2'b00, step});
  assign res      = d3_out.neg ? (p_ext + step_ext) : (p_ext - step_ext);

  always_comb begin
    if (res > 51'sd2147483647) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (res < -51'sd2147483648) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = res[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_data_q.elem_index_out <= d3_out.idx;
      out_data_q.param_updated  <= res_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/adam_ram.sv @@
// ----------------------------------------------------------------------------
// adam_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module adam_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/adam_div.sv @@
// ----------------------------------------------------------------------------
// adam_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Flags overflow when the quotient does not fit in QuoW bits.
// ----------------------------------------------------------------------------
module adam_div #(
  parameter int DenW = 17,
  parameter int QuoW = 48,
  parameter int PayW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [QuoW+DenW-1:0] num_i,
  input  logic [DenW-1:0]      den_i,
  input  logic [PayW-1:0]      pay_i,
  output logic                 valid_o,
  output logic [QuoW-1:0]      quo_o,
  output logic                 ovf_o,
  output logic [PayW-1:0]      pay_o
);

  logic [QuoW-1:0] vld_q;
  logic [DenW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] nq_q  [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic            ovf_q [QuoW];
  logic [PayW-1:0] pay_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic            v_src;
    logic [DenW-1:0] rem_src;
    logic [QuoW-1:0] nq_src;
    logic [DenW-1:0] den_src;
    logic            ovf_src;
    logic [PayW-1:0] pay_src;
    logic [DenW:0]   trial;
    logic            fits;

    if (k == 0) begin : g_first
      assign v_src   = valid_i;
      assign rem_src = num_i[QuoW+DenW-1:QuoW];
      assign nq_src  = num_i[QuoW-1:0];
      assign den_src = den_i;
      assign ovf_src = (num_i[QuoW+DenW-1:QuoW] >= den_i);
      assign pay_src = pay_i;
    end else begin : g_next
      assign v_src   = vld_q[k-1];
      assign rem_src = rem_q[k-1];
      assign nq_src  = nq_q[k-1];
      assign den_src = den_q[k-1];
      assign ovf_src = ovf_q[k-1];
      assign pay_src = pay_q[k-1];
    end

    // shift in the next numerator bit, subtract when the divisor fits
    assign trial = {rem_src, nq_src[QuoW-1]};
    assign fits  = (trial >= {1'b0, den_src});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? DenW'(trial - {1'b0, den_src}) : trial[DenW-1:0];
        nq_q[k]  <= {nq_src[QuoW-2:0], fits};
        den_q[k] <= den_src;
        ovf_q[k] <= ovf_src;
        pay_q[k] <= pay_src;
      end
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = nq_q[QuoW-1];
  assign ovf_o   = ovf_q[QuoW-1];
  assign pay_o   = pay_q[QuoW-1];

endmodule

@@ rtl/adam_sqrt.sv @@
// ----------------------------------------------------------------------------
// adam_sqrt
// Pipelined integer square root, one root bit per stage, with side payload.
// ----------------------------------------------------------------------------
module adam_sqrt #(
  parameter int RootW = 32,
  parameter int PayW  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2*RootW-1:0] x_i,
  input  logic [PayW-1:0]    pay_i,
  output logic               valid_o,
  output logic [RootW-1:0]   root_o,
  output logic [PayW-1:0]    pay_o
);

  logic [RootW-1:0]   vld_q;
  logic [RootW-1:0]   rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [2*RootW-1:0] x_q    [RootW];
  logic [PayW-1:0]    pay_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic               v_src;
    logic [RootW-1:0]   rem_src;
    logic [RootW-1:0]   root_src;
    logic [2*RootW-1:0] x_src;
    logic [PayW-1:0]    pay_src;
    logic [RootW+1:0]   rem2;
    logic [RootW+1:0]   trial;
    logic               fits;

    if (k == 0) begin : g_first
      assign v_src    = valid_i;
      assign rem_src  = '0;
      assign root_src = '0;
      assign x_src    = x_i;
      assign pay_src  = pay_i;
    end else begin : g_next
      assign v_src    = vld_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign x_src    = x_q[k-1];
      assign pay_src  = pay_q[k-1];
    end

    // bring down the next two radicand bits, try root*4 + 1
    assign rem2  = {rem_src, x_src[2*RootW-1:2*RootW-2]};
    assign trial = {root_src, 2'b01};
    assign fits  = (rem2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? RootW'(rem2 - trial) : rem2[RootW-1:0];
        root_q[k] <= {root_src[RootW-2:0], fits};
        x_q[k]    <= {x_src[2*RootW-3:0], 2'b00};
        pay_q[k]  <= pay_src;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign pay_o   = pay_q[RootW-1];

endmodule

@@ tb/adam_optimizer_update_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_optimizer_update_tb
// Self-checking bench for the fixed-point Adam element update. A scoreboard
// predicts the new parameter value of each accepted element from its own
// copy of the moment stores, step powers and registers, and compares every
// returned item in order. Directed corner items come first, then random
// optimizer steps under several register settings, with random idle bursts
// on the input and random stalls on the output, except in the final phase.
// ----------------------------------------------------------------------------
module adam_optimizer_update_tb;
  import adam_pkg::*;

  localparam int unsigned Elements   = DefElements;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 181;

  class adam_scoreboard;
    longint unsigned lr, b1, b2, eps;
    int              m1_store[Elements];
    longint unsigned m2_store[Elements];
    longint unsigned steps, pow1, pow2;
    adam_out_t       pending[$];
    int              errors;
    int              results;

    function new();
      lr    = LrReset;
      b1    = B1Reset;
      b2    = B2Reset;
      eps   = EpsReset;
      steps = 0;
      pow1  = 65536;
      pow2  = 65536;
      foreach (m1_store[i]) begin
        m1_store[i] = 0;
        m2_store[i] = 0;
      end
    endfunction

    function void set_reg(cfg_reg_e idx, longint unsigned val);
      case (idx)
        CfgLr:  lr  = val & 16'hFFFF;
        CfgB1:  b1  = val & 16'hFFFF;
        CfgB2:  b2  = val & 16'hFFFF;
        CfgEps: eps = val & 32'hFFFF_FFFF;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Expected new value of one element; updates the moment stores.
    function adam_out_t update_elem(adam_in_t it);
      int unsigned     slot;
      longint          pv, gv, acc, m1, res;
      longint unsigned mag, gmag, g2, m2, c1, c2, m1hat, m2hat, root, den, num, q, rem;
      bit              neg;
      adam_out_t       o;
      slot = it.elem_index % Elements;
      pv   = longint'($signed(it.param_value));
      gv   = longint'($signed(it.grad_value));
      if (it.starts_step) begin
        if (steps != 64'hFFFF_FFFF) steps++;
        pow1 = (pow1 * b1 + 32768) >> 16;
        pow2 = (pow2 * b2 + 32768) >> 16;
      end
      // round half away from zero
      acc = longint'(b1) * longint'(m1_store[slot]) + longint'(65536 - b1) * gv;
      mag = acc < 0 ? longint'(-acc) : acc;
      mag = (mag + 32768) >> 16;
      m1  = acc < 0 ? -longint'(mag) : longint'(mag);
      m1_store[slot] = int'(m1);
      gmag = gv < 0 ? -gv : gv;
      g2   = (gmag * gmag + 32768) >> 16;
      m2   = (b2 * m2_store[slot] + (65536 - b2) * g2 + 32768) >> 16;
      m2_store[slot] = m2;
      c1 = 65536 - pow1;
      c2 = 65536 - pow2;
      if (c1 == 0) c1 = 65536;
      if (c2 == 0) c2 = 65536;
      neg   = m1 < 0;
      mag   = neg ? -m1 : m1;
      m1hat = (mag << 16) / c1;
      m2hat = (m2 << 16) / c2;
      if (m2hat > 48'hFFFF_FFFF_FFFF) m2hat = 48'hFFFF_FFFF_FFFF;
      root = int_sqrt(m2hat << 16);
      den  = (root << 16) + eps;
      if (den == 0) den = 1;
      num = lr * m1hat;
      q   = num / den;
      if (q >= (64'd1 << 32)) begin
        q = 64'd1 << 48;
      end else begin
        rem = num % den;
        repeat (16) begin
          rem <<= 1;
          q   <<= 1;
          if (rem >= den) begin
            rem -= den;
            q   |= 1;
          end
        end
      end
      res = neg ? pv + longint'(q) : pv - longint'(q);
      if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
      if (res < -64'sh8000_0000) res = -64'sh8000_0000;
      o.elem_index_out = it.elem_index;
      o.param_updated  = res[31:0];
      return o;
    endfunction

    function void note_input(adam_in_t it);
      pending.push_back(update_elem(it));
    endfunction

    function void check_result(adam_out_t got);
      adam_out_t exp_o;
      results++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: index %0d value %0d",
               got.elem_index_out, got.param_updated);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.elem_index_out !== exp_o.elem_index_out) begin
        $error("elem_index_out: expected %0d, got %0d",
               exp_o.elem_index_out, got.elem_index_out);
        errors++;
      end
      if (got.param_updated !== exp_o.param_updated) begin
        $error("param_updated: expected %0d, got %0d",
               exp_o.param_updated, got.param_updated);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  adam_in_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  adam_out_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  adam_scoreboard  sb = new();
  bit              quiet = 1'b0;
  int unsigned     cycles = 0;
  int unsigned     sent = 0;

  adam_optimizer_update #(.ELEMENTS(Elements)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Output back-pressure in random bursts.
  initial begin
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] lr, logic [15:0] b1, logic [15:0] b2,
                         logic [31:0] eps);
    write_reg(CfgLr, lr);
    write_reg(CfgB1, b1);
    write_reg(CfgB2, b2);
    write_reg(CfgEps, eps);
  endtask

  // Call right after the clock rises; returns right after the item is taken.
  task automatic send_elem(logic [9:0] idx, logic [31:0] pv, logic [31:0] gv, bit st);
    adam_in_t it;
    it.elem_index  = idx;
    it.param_value = pv;
    it.grad_value  = gv;
    it.starts_step = st;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      2: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  // Random optimizer steps over a small working set, plus stray items.
  task automatic random_phase(int unsigned n);
    int unsigned k, base, cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 6) == 0) begin
        send_elem(10'($urandom()), $urandom(), rand_grad(), 1'($urandom()));
        cnt++;
      end else begin
        k    = $urandom_range(1, 12);
        base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 8);
        for (int unsigned j = 0; j < k; j++) begin
          send_elem(10'(base + j),
                    $urandom_range(0, 3) == 0 ? $urandom()
                      : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                    rand_grad(), j == 0);
          cnt++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First items open no step, so bias corrections fall back to one.
    send_elem(10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_elem(10'd1023, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_elem(10'd0, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    send_elem(10'd700, 32'h0, 32'h0, 1'b0);
    send_elem(10'd1, 32'h0000_8000, 32'h0001_0000, 1'b1);
    send_elem(10'd1, 32'hFFFF_8000, 32'hFFFF_FFFF, 1'b0);
    send_elem(10'd2, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_elem(10'd2, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_elem(10'd1023, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    drain();

    // Zero epsilon and zero decay: zero denominator on a fresh entry,
    // and a huge step that saturates the result.
    set_all(16'hFFFF, 16'h0, 16'h0, 32'h0);
    send_elem(10'd500, 32'h1234_5678, 32'h0, 1'b1);
    send_elem(10'd501, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_elem(10'd502, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_elem(10'd503, 32'h0, 32'h0000_0001, 1'b0);
    drain();

    // Decays at full scale: bias correction becomes one LSB.
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_elem(10'd510, 32'h0, 32'h0001_0000, 1'b1);
    send_elem(10'd511, 32'h7FFF_0000, 32'hFFFE_0000, 1'b0);
    send_elem(10'd512, 32'h0, 32'h8000_0000, 1'b1);
    drain();

    set_all(16'd0, 16'd32768, 16'd49152, 32'd1);
    random_phase(150);
    drain();
    set_all(LrReset, B1Reset, B2Reset, EpsReset);
    random_phase(400);
    drain();
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);
    random_phase(200);
    drain();
    set_all(16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom());
    random_phase(300);
    drain();
    set_all(16'd1000, 16'd60000, 16'd65000, 32'd65536);
    random_phase(300);
    drain();

    quiet = 1'b1;
    set_all(16'($urandom()), 16'($urandom_range(50000, 65535)), 16'($urandom()), 32'd0);
    random_phase(280);
    drain();

    $display("Covered %0d elements and %0d results under eight register settings,",
             sent, sb.results);
    $display("from reset defaults to full-scale decays and a zero epsilon.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
